// ===== hw/rtl/vrm_pkg.sv =====
// Package for the voxel ray mask DDA core: shared widths and the per-ray pipeline record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vrm_pkg;
  localparam int unsigned QW = 32;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  px;
    logic [2:0]  py;
    logic [2:0]  pz;
    logic        nx;
    logic        ny;
    logic        nz;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
    logic        done;
    logic [63:0] mask;
  } walk_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[32] ? SAT32 : s[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/voxel_ray_mask_dda_core.sv =====
// Top level of the voxel ray mask DDA core: reciprocal, setup and DDA step pipeline.
// Depends on vrm_pkg.
`timescale 1ns / 1ps
`default_nettype none
// One ray per cycle while the output is not stalled. A restoring divider of
// 32 one-bit stages forms each axis reciprocal 2^31/|dir| (three lanes side by side),
// two stages form the first side distances (one multiply, then shift and saturate),
// and one stage per DDA step walks the brick. The whole pipe advances only when the
// output register is empty or being drained, so a stall loses nothing.
module voxel_ray_mask_dda_core #(
  parameter int MAX_STEPS = 12
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // origin_x[15:0], origin_y[31:16], origin_z[47:32], dir_x[63:48], dir_y[79:64],
  // dir_z[95:80]
  input  wire logic [95:0]  s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // cell_mask[63:0]
  output logic [63:0]       m_tdata
);
  localparam int DV = 32;           // divider stages

  logic adv;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // divider lanes: remainder, quotient, divisor
  logic [32:0] rem [3][DV+1];
  logic [31:0] quo [3][DV+1];
  logic [15:0] mag [3][DV+1];
  logic [15:0] org [3][DV+1];
  logic        neg [3][DV+1];
  logic        v   [DV+1];

  for (genvar a = 0; a < 3; a++) begin : g_in
    assign org[a][0] = s_tdata[a*16 +: 16];
    assign neg[a][0] = s_tdata[48 + a*16 + 15];
    assign mag[a][0] = neg[a][0] ? 16'(17'h10000 - {1'b0, s_tdata[48 + a*16 +: 16]})
                                 : s_tdata[48 + a*16 +: 16];
    assign rem[a][0] = '0;
    assign quo[a][0] = '0;
  end
  assign v[0] = s_tvalid;

  for (genvar k = 0; k < DV; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) v[k+1] <= 1'b0;
      else if (adv) v[k+1] <= v[k];
    end
    for (genvar a = 0; a < 3; a++) begin : g_ax
      logic [32:0] r;
      logic [32:0] m17;
      always_comb begin
        // dividend is 2^31: bit 31-k
        r = {rem[a][k][31:0], (k == 0) ? 1'b1 : 1'b0};
        m17 = {17'b0, mag[a][k]};
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          if (r >= m17 && mag[a][k] != 16'd0) begin
            rem[a][k+1] <= r - m17;
            quo[a][k+1] <= {quo[a][k][30:0], 1'b1};
          end else begin
            rem[a][k+1] <= r;
            quo[a][k+1] <= {quo[a][k][30:0], 1'b0};
          end
          mag[a][k+1] <= mag[a][k];
          org[a][k+1] <= org[a][k];
          neg[a][k+1] <= neg[a][k];
        end
      end
    end
  end

  // setup stage A: multiply
  logic        va, vb;
  logic [46:0] prod [3];
  logic [31:0] dla  [3];
  logic        za   [3];
  logic [15:0] orga [3];
  logic        nga  [3];
  vrm_pkg::walk_t w [MAX_STEPS+1];
  logic        vw   [MAX_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin va <= 1'b0; vb <= 1'b0; end
    else if (adv) begin va <= v[DV]; vb <= va; end
  end

  for (genvar a = 0; a < 3; a++) begin : g_set
    logic [14:0] s;
    always_comb s = neg[a][DV] ? {1'b0, org[a][DV][13:0]}
                               : 15'(15'd16384 - {1'b0, org[a][DV][13:0]});
    always_ff @(posedge clk) begin
      if (adv) begin
        prod[a] <= 47'(s) * 47'(quo[a][DV]);
        dla[a]  <= quo[a][DV];
        za[a]   <= mag[a][DV] == 16'd0;
        orga[a] <= org[a][DV];
        nga[a]  <= neg[a][DV];
      end
    end
  end

  // setup stage B: shift, saturate, build walk record
  always_ff @(posedge clk) begin
    if (adv) begin
      w[0].px <= {1'b0, orga[0][15:14]};
      w[0].py <= {1'b0, orga[1][15:14]};
      w[0].pz <= {1'b0, orga[2][15:14]};
      w[0].nx <= nga[0]; w[0].ny <= nga[1]; w[0].nz <= nga[2];
      w[0].dx <= za[0] ? vrm_pkg::SAT32 : dla[0];
      w[0].dy <= za[1] ? vrm_pkg::SAT32 : dla[1];
      w[0].dz <= za[2] ? vrm_pkg::SAT32 : dla[2];
      w[0].sx <= (za[0] || prod[0][46:46]) ? vrm_pkg::SAT32 : prod[0][45:14];
      w[0].sy <= (za[1] || prod[1][46:46]) ? vrm_pkg::SAT32 : prod[1][45:14];
      w[0].sz <= (za[2] || prod[2][46:46]) ? vrm_pkg::SAT32 : prod[2][45:14];
      w[0].done <= 1'b0;
      w[0].mask <= '0;
    end
  end
  assign vw[0] = vb;

  // DDA steps
  for (genvar k = 0; k < MAX_STEPS; k++) begin : g_step
    vrm_pkg::walk_t c, n;
    always_comb begin
      c = w[k];
      n = c;
      if (!c.done) begin
        if (c.px[2] || c.py[2] || c.pz[2]) begin
          n.done = 1'b1;
        end else begin
          n.mask = c.mask | (64'd1 << {c.py[1:0], c.pz[1:0], c.px[1:0]});
          if (c.sx < c.sy && c.sx < c.sz) begin
            n.sx = vrm_pkg::sat_add(c.sx, c.dx);
            n.px = c.nx ? c.px - 3'd1 : c.px + 3'd1;
          end else if (c.sy < c.sz) begin
            n.sy = vrm_pkg::sat_add(c.sy, c.dy);
            n.py = c.ny ? c.py - 3'd1 : c.py + 3'd1;
          end else begin
            n.sz = vrm_pkg::sat_add(c.sz, c.dz);
            n.pz = c.nz ? c.pz - 3'd1 : c.pz + 3'd1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vw[k+1] <= 1'b0;
      else if (adv) vw[k+1] <= vw[k];
      if (adv) w[k+1] <= n;
    end
  end

  assign m_tvalid = vw[MAX_STEPS];
  assign m_tdata  = w[MAX_STEPS].mask;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed under stall");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    s_tready |=> vw[1] == $past(vw[0]))
    else $error("valid lost in pipe");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while pipe stalled");
`endif
endmodule
`default_nettype wire

// ===== dv/voxel_ray_mask_dda_checker.sv =====
// Checker for the voxel ray mask DDA core: watches both stream channels, predicts each
// cell mask from the accepted ray and compares it with the delivered one.
// Standalone; no package types needed.
`timescale 1ns / 1ps
module voxel_ray_mask_dda_checker #(
  parameter int MAX_STEPS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [95:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [63:0] m_tdata,
  output int               fail_count,
  output int               pending,
  output int               mask_count
);
  logic [63:0] mask_q[$];

  // One axis: start cell, step sign, step length and first side distance (Q16.16).
  function automatic void axis_setup(input logic [15:0] org, input logic [15:0] dir,
                                     output int start, output bit neg,
                                     output logic [31:0] delta, output logic [31:0] side);
    logic [16:0] mag;
    logic [14:0] s;
    logic [63:0] prod;
    start = org[15:14];
    neg  = dir[15];
    mag  = neg ? (17'h10000 - {1'b0, dir}) : {1'b0, dir};
    if (mag == 0) begin
      delta = 32'hFFFF_FFFF;
      side  = 32'hFFFF_FFFF;
    end else begin
      delta = 32'((64'd1 << 31) / mag);
      s     = neg ? {1'b0, org[13:0]} : (15'd16384 - {1'b0, org[13:0]});
      prod  = (64'(s) * 64'(delta)) >> 14;
      side  = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    end
  endfunction

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[32] ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  function automatic logic [63:0] walk_mask(input logic [95:0] ray);
    int p[3];
    bit n[3];
    logic [31:0] d[3], sd[3];
    logic [63:0] m;
    int ax;
    m = '0;
    for (int a = 0; a < 3; a++)
      axis_setup(ray[16*a +: 16], ray[48 + 16*a +: 16], p[a], n[a], d[a], sd[a]);
    for (int i = 0; i < MAX_STEPS; i++) begin
      if (p[0] < 0 || p[0] > 3 || p[1] < 0 || p[1] > 3 || p[2] < 0 || p[2] > 3) break;
      m[p[0] + 4*p[2] + 16*p[1]] = 1'b1;
      // x only when strictly smallest, then y if below z, z otherwise
      if (sd[0] < sd[1] && sd[0] < sd[2]) ax = 0;
      else if (sd[1] < sd[2]) ax = 1;
      else ax = 2;
      sd[ax] = add_sat(sd[ax], d[ax]);
      p[ax]  = n[ax] ? p[ax] - 1 : p[ax] + 1;
    end
    return m;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    mask_count = 0;
  end
  assign pending = mask_q.size();

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) mask_q.push_back(walk_mask(s_tdata));
      if (m_tvalid && m_tready) begin
        if (mask_q.size() == 0) report("unexpected transfer", m_tdata, '0);
        else begin
          if (m_tdata !== mask_q[0]) report("cell_mask", m_tdata, mask_q[0]);
          void'(mask_q.pop_front());
          mask_count++;
        end
      end
    end
  end
endmodule

// ===== dv/voxel_ray_mask_dda_core_tb.sv =====
// Testbench top for the voxel ray mask DDA core: drives rays with random gaps and
// back-pressure, gives the verdict. Depends on the core and voxel_ray_mask_dda_checker.
`timescale 1ns / 1ps
module voxel_ray_mask_dda_core_tb;
  localparam int LATENCY = 32 + 2 + 12;
  localparam int N_RANDOM = 854;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0;
  logic [95:0] s_tdata = '0;
  logic s_tready, m_tvalid;
  logic [63:0] m_tdata;
  int fail_count, pending, mask_count;
  int cycles = 0;
  bit quiet_tail = 0;    // last part of the run: no idling on either side
  bit hold_sink = 0;     // long receiver hold-off
  logic [95:0] rays[$];

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  voxel_ray_mask_dda_core #(.MAX_STEPS(12)) i_dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  voxel_ray_mask_dda_checker #(.MAX_STEPS(12)) i_chk (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending), .mask_count(mask_count)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off while rays keep coming.
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        for (int i = 0; i < 200; i++) @(posedge clk);
        hold_sink = 0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic logic [15:0] pick_dir();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'h0001;
      4: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_org();
    case ($urandom_range(0, 5))
      0: return {2'($urandom), 14'h0000};
      1: return {2'($urandom), 14'h3FFF};
      2: return {2'($urandom), 14'h2000};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_ray(input logic [95:0] ray, input bit gaps);
    int n;
    if (gaps && !quiet_tail && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      n = $urandom_range(1, 12);
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ray;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [15:0] o[3], d[3];
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all-zero direction, axis-aligned both ways, extreme magnitudes,
    // saturated ties, corner origins, exact cell boundaries.
    rays.push_back({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    rays.push_back({16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000});
    rays.push_back({16'h0000, 16'h0000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    rays.push_back({16'h0000, 16'h7FFF, 16'h0000, 16'h2000, 16'h2000, 16'h2000});
    rays.push_back({16'h8000, 16'h0000, 16'h0000, 16'hC000, 16'hC000, 16'hC000});
    rays.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000});
    rays.push_back({16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    rays.push_back({16'h0001, 16'h0001, 16'h0001, 16'h4000, 16'h4000, 16'h4000});
    rays.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h2000, 16'h2000, 16'h2000});
    rays.push_back({16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    rays.push_back({16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000});
    rays.push_back({16'h1000, 16'h1000, 16'h1000, 16'h6000, 16'h6000, 16'h6000});
    rays.push_back({16'h7FFF, 16'h8000, 16'h7FFF, 16'h3FFF, 16'h3FFF, 16'h3FFF});
    rays.push_back({16'h0000, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hC000, 16'h0000});
    rays.push_back({16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
    rays.push_back({16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555});
    foreach (rays[i]) send_ray(rays[i], 0);
    drain();

    // Long receiver hold-off while the sender keeps offering rays.
    hold_sink = 1;
    for (int i = 0; i < 80; i++) begin
      for (int a = 0; a < 3; a++) begin o[a] = 16'($urandom); d[a] = 16'($urandom); end
      send_ray({d[2], d[1], d[0], o[2], o[1], o[0]}, 0);
    end
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 150) quiet_tail = 1;
      for (int a = 0; a < 3; a++) begin o[a] = pick_org(); d[a] = pick_dir(); end
      send_ray({d[2], d[1], d[0], o[2], o[1], o[0]}, 1);
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d rays: zero, extreme and random directions, corner origins,",
             mask_count);
    $display("with random gaps, stall bursts and one long output hold-off.");
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/vrm_pkg.sv
hw/rtl/voxel_ray_mask_dda_core.sv
dv/voxel_ray_mask_dda_checker.sv
dv/voxel_ray_mask_dda_core_tb.sv
